// ===== rtl/core/tlp_pkg.sv =====
`default_nettype none
package tlp_pkg;

  localparam int DATA_W      = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_DIM_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = CFG_DIM_W;
  localparam int DIM_CAP     = (1 << CFG_DIM_W) - 1;

  localparam int MAX_ELEMS_DEF = 4096;
  localparam int MAX_DIM_DEF   = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERM_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_C     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_W     = 3'd3;

  // Permutation modes.
  localparam logic [MODE_W-1:0] MODE_CHW_HWC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HWC_CHW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNSUP   = 2'd3;

  // Request kinds carried in the input tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic capture;
    logic stage1;
    logic stage2;
    logic exec;
    logic load_out;
  } tlp_cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic out_free;
  } tlp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlp_ctrl.sv =====
`default_nettype none
module tlp_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  tlp_pkg::tlp_sts_t  sts,
  output tlp_pkg::tlp_cmd_t  cmd
);
  import tlp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.stage1 = 1'b1;
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        cmd.stage2 = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_fetch ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        // The finished result waits here until the output register frees up.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.stage1, cmd.stage2, cmd.exec, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  a_capture_then_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.stage1)
    else $error("captured transaction did not enter the first multiply stage");

endmodule
`default_nettype wire

// ===== rtl/core/tlp_datapath.sv =====
`default_nettype none
module tlp_datapath #(
  parameter int MAX_ELEMS = tlp_pkg::MAX_ELEMS_DEF,
  parameter int MAX_DIM   = tlp_pkg::MAX_DIM_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [tlp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire  [tlp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire  [tlp_pkg::DATA_W-1:0]         in_tdata,
  input  wire                                in_tuser,
  output logic [tlp_pkg::DATA_W-1:0]         out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  tlp_pkg::tlp_cmd_t                  cmd,
  output tlp_pkg::tlp_sts_t                  sts
);
  import tlp_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < DIM_CAP) ? MAX_DIM : DIM_CAP;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam int IDX_W   = $clog2(EFF_MAX);
  localparam int PR_W    = 2 * DIM_W;
  localparam int MB_W    = IDX_W + DIM_W;
  localparam int TOT_W   = 3 * DIM_W;
  localparam int ADDR_W  = $clog2(MAX_ELEMS);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > 32'(EFF_MAX)) begin
      return DIM_W'(EFF_MAX);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  // Configuration registers.
  logic [MODE_W-1:0]    mode_r;
  logic [CFG_DIM_W-1:0] dim_c_r;
  logic [CFG_DIM_W-1:0] dim_h_r;
  logic [CFG_DIM_W-1:0] dim_w_r;
  logic                 cfg_hit;

  // Position state.
  logic [TOT_W-1:0]     load_cnt_r;
  logic [IDX_W-1:0]     outer_r;
  logic [IDX_W-1:0]     middle_r;
  logic [IDX_W-1:0]     inner_r;

  // Captured item and pipeline registers.
  logic                 req_r;
  logic [DATA_W-1:0]    value_r;
  logic [PR_W-1:0]      hw_r;
  logic [PR_W-1:0]      ma_r;
  logic [MB_W-1:0]      mb_r;
  logic [TOT_W-1:0]     tot_r;
  logic [TOT_W-1:0]     addr_r;
  logic [DATA_W-1:0]    rd_r;
  logic                 inrange_r;
  logic                 last_r;
  logic                 err_r;

  // Output register.
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_last_r;
  logic                 out_user_r;

  logic [DATA_W-1:0]    mem [MAX_ELEMS];

  logic [DIM_W-1:0]     ec;
  logic [DIM_W-1:0]     eh;
  logic [DIM_W-1:0]     ew;
  logic [DIM_W-1:0]     n_outer;
  logic [DIM_W-1:0]     n_middle;
  logic [DIM_W-1:0]     n_inner;
  logic [IDX_W-1:0]     idx_j;
  logic [IDX_W-1:0]     idx_k;
  logic [PR_W-1:0]      hw_nxt;
  logic [PR_W-1:0]      wc_nxt;
  logic [PR_W-1:0]      ma_nxt;
  logic [MB_W-1:0]      mb_nxt;
  logic [TOT_W-1:0]     addr_nxt;
  logic [TOT_W-1:0]     tot_nxt;
  logic [TOT_W:0]       lc_inc;
  logic [TOT_W-1:0]     load_cnt_nxt;
  logic [DIM_W-1:0]     outer_inc;
  logic [DIM_W-1:0]     middle_inc;
  logic [DIM_W-1:0]     inner_inc;
  logic                 wrap_inner;
  logic                 wrap_middle;
  logic                 wrap_outer;
  logic                 last_nxt;

  assign ec = eff_dim(dim_c_r);
  assign eh = eff_dim(dim_h_r);
  assign ew = eff_dim(dim_w_r);

  assign cfg_hit = cfg_we && ((cfg_addr == REG_PERM_MODE) || (cfg_addr == REG_DIM_C) ||
                              (cfg_addr == REG_DIM_H) || (cfg_addr == REG_DIM_W));

  // Loop bounds and address terms for each output order.
  always_comb begin
    unique case (mode_r)
      MODE_HWC_CHW: begin
        n_outer  = ec;
        n_middle = eh;
        n_inner  = ew;
        idx_j    = middle_r;
        idx_k    = outer_r;
      end
      MODE_SWAP: begin
        n_outer  = eh;
        n_middle = ec;
        n_inner  = ew;
        idx_j    = middle_r;
        idx_k    = inner_r;
      end
      default: begin
        n_outer  = eh;
        n_middle = ew;
        n_inner  = ec;
        idx_j    = inner_r;
        idx_k    = middle_r;
      end
    endcase
  end

  assign hw_nxt = PR_W'(eh * ew);
  assign wc_nxt = PR_W'(ew * ec);
  assign ma_nxt = (mode_r == MODE_HWC_CHW) ? wc_nxt : hw_nxt;
  assign mb_nxt = (mode_r == MODE_HWC_CHW) ? MB_W'(inner_r * ec) : MB_W'(outer_r * ew);

  assign tot_nxt  = TOT_W'(hw_r * ec);
  assign addr_nxt = TOT_W'(idx_j * ma_r) + TOT_W'(mb_r) + TOT_W'(idx_k);

  assign lc_inc       = {1'b0, load_cnt_r} + (TOT_W + 1)'(1);
  assign load_cnt_nxt = (lc_inc >= {1'b0, tot_r}) ? '0 : lc_inc[TOT_W-1:0];

  assign outer_inc   = DIM_W'(outer_r) + DIM_W'(1);
  assign middle_inc  = DIM_W'(middle_r) + DIM_W'(1);
  assign inner_inc   = DIM_W'(inner_r) + DIM_W'(1);
  assign wrap_inner  = (inner_inc >= n_inner);
  assign wrap_middle = (middle_inc >= n_middle);
  assign wrap_outer  = (outer_inc >= n_outer);
  assign last_nxt    = wrap_inner && wrap_middle && wrap_outer;

  // Configuration and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CHW_HWC;
      dim_c_r    <= CFG_DIM_W'(1);
      dim_h_r    <= CFG_DIM_W'(1);
      dim_w_r    <= CFG_DIM_W'(1);
      load_cnt_r <= '0;
      outer_r    <= '0;
      middle_r   <= '0;
      inner_r    <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_addr)
        REG_PERM_MODE: mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_DIM_C:     dim_c_r <= cfg_wdata;
        REG_DIM_H:     dim_h_r <= cfg_wdata;
        default:       dim_w_r <= cfg_wdata;
      endcase
      load_cnt_r <= '0;
      outer_r    <= '0;
      middle_r   <= '0;
      inner_r    <= '0;
    end else if (cmd.exec) begin
      if (req_r == REQ_LOAD) begin
        load_cnt_r <= load_cnt_nxt;
      end else if (mode_r != MODE_UNSUP) begin
        // Innermost index runs fastest; each wrap carries into the next one.
        if (wrap_inner) begin
          inner_r <= '0;
          if (wrap_middle) begin
            middle_r <= '0;
            outer_r  <= wrap_outer ? '0 : outer_inc[IDX_W-1:0];
          end else begin
            middle_r <= middle_inc[IDX_W-1:0];
          end
        end else begin
          inner_r <= inner_inc[IDX_W-1:0];
        end
      end
    end
  end

  // Item capture, the two multiply stages and the fetch result flags.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_tuser;
      value_r <= in_tdata;
    end
    if (cmd.stage1) begin
      hw_r <= hw_nxt;
      ma_r <= ma_nxt;
      mb_r <= mb_nxt;
    end
    if (cmd.stage2) begin
      tot_r  <= tot_nxt;
      addr_r <= addr_nxt;
    end
    if (cmd.exec && (req_r == REQ_FETCH)) begin
      inrange_r <= (32'(addr_r) < 32'(MAX_ELEMS));
      last_r    <= (mode_r != MODE_UNSUP) && last_nxt;
      err_r     <= (mode_r == MODE_UNSUP);
    end
  end

  // Image store: one write port for loads, one registered read port for fetches.
  always_ff @(posedge clk) begin
    if (cmd.exec && (req_r == REQ_LOAD) && (32'(load_cnt_r) < 32'(MAX_ELEMS))) begin
      mem[ADDR_W'(load_cnt_r)] <= value_r;
    end
    if (cmd.exec && (req_r == REQ_FETCH)) begin
      rd_r <= mem[ADDR_W'(addr_r)];
    end
  end

  // Output register; a new result may be loaded in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= (err_r || !inrange_r) ? '0 : rd_r;
      out_last_r <= last_r;
      out_user_r <= err_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser    = out_user_r;
  assign sts.is_fetch = (req_r == REQ_FETCH);
  assign sts.out_free = !out_valid_r || out_tready;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (DIM_W'(outer_r) < n_outer) && (DIM_W'(middle_r) < n_middle) &&
    (DIM_W'(inner_r) < n_inner))
    else $error("fetch position outside the current image");

  a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r |-> (out_data_r == '0) && !out_last_r)
    else $error("error result carries data or a last flag");

  a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded but output not valid");

endmodule
`default_nettype wire

// ===== rtl/core/tensor_layout_permute.sv =====
`default_nettype none
// A fetch passes capture, two multiply stages, the store read and the result step before out_tvalid.
// The controller takes a new input item only after the last one is through, stepping each item
// through two multiply stages and the store access in turn; loads skip the result step.
// A full output register stalls the next fetch in its result step until out_tready.
// Reset (rst_n, synchronous, active low) restores mode 0, all dimensions 1, and clears
// the load count, fetch position and output valid; the image store keeps its contents.
module tensor_layout_permute #(
  parameter int MAX_ELEMS = tlp_pkg::MAX_ELEMS_DEF,
  parameter int MAX_DIM   = tlp_pkg::MAX_DIM_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [tlp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [tlp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [tlp_pkg::DATA_W-1:0]      in_tdata,   // [31:0] element_value
  input  wire                             in_tuser,   // [0] req_type
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [tlp_pkg::DATA_W-1:0]      out_tdata,  // [31:0] out_value
  output logic                            out_tlast,  // last_of_image
  output logic                            out_tuser   // [0] status
);
  import tlp_pkg::*;

  tlp_cmd_t cmd;
  tlp_sts_t sts;

  tlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlp_datapath #(
    .MAX_ELEMS (MAX_ELEMS),
    .MAX_DIM   (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
